// ----- hw/rtl/clws_pkg.sv -----
`timescale 1ns / 1ps

package clws_pkg;

	typedef enum logic [1:0] {
		ACT_CMD    = 2'd0,
		ACT_CHAR   = 2'd1,
		ACT_INIT   = 2'd2,
		ACT_CURSOR = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		CFG_BUS_MODE     = 2'd0,
		CFG_STROBE_HOLD  = 2'd1,
		CFG_POWERUP_HOLD = 2'd2
	} cfg_index_t;

	localparam int CfgDataW   = 24;
	localparam int StrobeW    = 16;
	localparam int HoldW      = 24;
	localparam int PhaseIdxW  = 5;
	localparam int ByteIdxW   = 3;

	localparam logic [StrobeW-1:0] StrobeHoldReset  = 16'd4000;
	localparam logic [HoldW-1:0]   PowerupHoldReset = 24'd5000000;

	localparam logic [7:0] CmdFunc8    = 8'h38;
	localparam logic [7:0] CmdHome4    = 8'h02;
	localparam logic [7:0] CmdFunc4    = 8'h28;
	localparam logic [7:0] CmdDispOn   = 8'h0C;
	localparam logic [7:0] CmdClear    = 8'h01;
	localparam logic [7:0] CmdEntry    = 8'h06;
	localparam logic [7:0] CmdRow0Base = 8'h80;
	localparam logic [7:0] CmdRow1Base = 8'hC0;
	localparam logic [7:0] NibbleMask  = 8'hF0;

	typedef struct packed {
		action_t     action;
		logic [7:0]  data_byte;
		logic [1:0]  row;
		logic [4:0]  column;
	} request_t;

	typedef struct packed {
		logic             reg_select;
		logic             enable_line;
		logic [7:0]       bus_data;
		logic [HoldW-1:0] hold_ticks;
		logic             last_phase;
	} phase_t;

	// Init command bytes, eight-bit bus.
	function automatic logic [7:0] init_byte8(input logic [ByteIdxW-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = CmdFunc8;
			3'd1:    b = CmdDispOn;
			3'd2:    b = CmdClear;
			3'd3:    b = CmdEntry;
			default: b = CmdEntry;
		endcase
		return b;
	endfunction

	// Init command bytes, four-bit bus.
	function automatic logic [7:0] init_byte4(input logic [ByteIdxW-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			3'd0:    b = CmdHome4;
			3'd1:    b = CmdFunc4;
			3'd2:    b = CmdDispOn;
			3'd3:    b = CmdClear;
			3'd4:    b = CmdEntry;
			default: b = CmdEntry;
		endcase
		return b;
	endfunction

endpackage

// ----- hw/rtl/clws_if.sv -----
`timescale 1ns / 1ps

interface clws_req_if;
	logic                 valid;
	logic                 ready;
	clws_pkg::action_t    action;
	logic [7:0]           data_byte;
	logic [1:0]           row;
	logic [4:0]           column;

	modport source (output valid, action, data_byte, row, column, input ready);
	modport sink   (input valid, action, data_byte, row, column, output ready);
endinterface

interface clws_phase_if;
	logic                        valid;
	logic                        ready;
	logic                        reg_select;
	logic                        enable_line;
	logic [7:0]                  bus_data;
	logic [clws_pkg::HoldW-1:0]  hold_ticks;
	logic                        last_phase;

	modport source (output valid, reg_select, enable_line, bus_data, hold_ticks, last_phase,
		input ready);
	modport sink   (input valid, reg_select, enable_line, bus_data, hold_ticks, last_phase,
		output ready);
endinterface

// ----- hw/rtl/clws_phase_gen.sv -----
`timescale 1ns / 1ps

module clws_phase_gen (
	input  clws_pkg::request_t                 req,
	input  logic [clws_pkg::PhaseIdxW-1:0]     phase_idx,
	input  logic                               bus_mode,
	input  logic [clws_pkg::StrobeW-1:0]       strobe_hold,
	input  logic [clws_pkg::HoldW-1:0]         powerup_hold,
	output clws_pkg::phase_t                   phase
);
	import clws_pkg::*;

	logic                  is_init;
	logic [PhaseIdxW-1:0]  p;
	logic [ByteIdxW-1:0]   byte_idx;
	logic [ByteIdxW-1:0]   n_bytes;
	logic [PhaseIdxW-1:0]  n_phases;
	logic [7:0]            cur_byte;
	logic [7:0]            base;
	logic [7:0]            bus;
	logic [HoldW-1:0]      strobe_ticks;
	logic [HoldW-1:0]      powerup_ticks;

	assign is_init  = (req.action == ACT_INIT);
	// Byte phases start after the power-up wait during init.
	assign p        = is_init ? phase_idx - PhaseIdxW'(1) : phase_idx;
	assign byte_idx = bus_mode ? p[4:2] : p[3:1];
	assign base     = req.row[0] ? CmdRow1Base : CmdRow0Base;

	always_comb begin
		unique case (req.action)
			ACT_CMD, ACT_CHAR: begin
				cur_byte = req.data_byte;
				n_bytes  = 3'd1;
			end
			ACT_INIT: begin
				cur_byte = bus_mode ? init_byte4(byte_idx) : init_byte8(byte_idx);
				n_bytes  = bus_mode ? 3'd5 : 3'd4;
			end
			ACT_CURSOR: begin
				cur_byte = (byte_idx == '0) ? base : base + {3'b000, req.column};
				n_bytes  = 3'd2;
			end
			default: begin
				cur_byte = req.data_byte;
				n_bytes  = 3'd1;
			end
		endcase
	end

	// Two phases per byte on the eight-bit bus, four on the nibble bus.
	assign n_phases = (bus_mode ? {n_bytes, 2'b00} : {1'b0, n_bytes, 1'b0})
		+ PhaseIdxW'(is_init);

	always_comb begin
		if (!bus_mode)
			bus = cur_byte;
		else if (!p[1])
			bus = cur_byte & NibbleMask;
		else
			bus = {cur_byte[3:0], 4'b0000};
	end

	assign strobe_ticks  = (strobe_hold == '0) ? HoldW'(1) : HoldW'(strobe_hold);
	assign powerup_ticks = (powerup_hold == '0) ? HoldW'(1) : powerup_hold;

	always_comb begin
		phase.last_phase = (phase_idx == n_phases - PhaseIdxW'(1));
		if (is_init && phase_idx == '0) begin
			phase.reg_select  = 1'b0;
			phase.enable_line = 1'b0;
			phase.bus_data    = 8'h00;
			phase.hold_ticks  = powerup_ticks;
		end else begin
			phase.reg_select  = (req.action == ACT_CHAR);
			phase.enable_line = !p[0];
			phase.bus_data    = bus;
			phase.hold_ticks  = strobe_ticks;
		end
	end

endmodule

// ----- hw/rtl/char_lcd_write_sequencer_top.sv -----
`timescale 1ns / 1ps

// Character LCD write sequencer. Each request transaction (write command, write
// character, init, set cursor) turns into a run of pin-phase transactions, one
// per clock unless the receiver stalls, each giving RS, EN, D7..D0, a hold time
// in ticks and a last-phase flag. A byte costs 2 phases on the eight-bit bus and
// 4 on the nibble bus, so a byte write makes 2 or 4 phases, init 9 or 21 and set
// cursor 4 or 8; a set-cursor request with a row above 1 or a column above 15 is
// accepted and produces nothing. The phase counter steps through the request
// held in the request register. The next request is taken in the same cycle
// as the current one's final phase enters the output register; a request goes
// through the request register, then the output register, before its first
// phase shows. Configuration (bus_mode, strobe hold, power-up hold at indexes
// 0..2) must be written only while the block is idle; other indexes are ignored.
module char_lcd_write_sequencer_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [clws_pkg::CfgDataW-1:0]  cfg_data,
	clws_req_if.sink                       req,
	clws_phase_if.source                   phase
);
	import clws_pkg::*;

	// Configuration registers.
	logic                  bus_mode_q;
	logic [StrobeW-1:0]    strobe_hold_q;
	logic [HoldW-1:0]      powerup_hold_q;

	// Request held while its phases are generated.
	logic                  busy_q;
	request_t              req_q;
	logic [PhaseIdxW-1:0]  idx_q;

	// Output register toward the bus driver.
	logic                  out_valid_q;
	phase_t                out_q;

	phase_t                next_phase;
	logic                  advance;
	logic                  take;
	logic                  req_ok;

	clws_phase_gen u_phase_gen (
		.req          (req_q),
		.phase_idx    (idx_q),
		.bus_mode     (bus_mode_q),
		.strobe_hold  (strobe_hold_q),
		.powerup_hold (powerup_hold_q),
		.phase        (next_phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_mode_q     <= 1'b0;
			strobe_hold_q  <= StrobeHoldReset;
			powerup_hold_q <= PowerupHoldReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BUS_MODE:     bus_mode_q     <= cfg_data[0];
				CFG_STROBE_HOLD:  strobe_hold_q  <= cfg_data[StrobeW-1:0];
				CFG_POWERUP_HOLD: powerup_hold_q <= cfg_data[HoldW-1:0];
				default: ;
			endcase
		end
	end

	// Advance one phase whenever the output register is free or being drained.
	assign advance   = busy_q && (!out_valid_q || phase.ready);
	assign req.ready = !busy_q || (advance && next_phase.last_phase);
	assign take      = req.valid && req.ready;

	// Drop an out-of-range cursor request at acceptance.
	assign req_ok = !(req.action == ACT_CURSOR && (req.row[1] || req.column[4]));

	// A new request restarts the counter, even when it lands on the final phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= req_ok;
			idx_q  <= '0;
		end else if (advance) begin
			idx_q <= idx_q + PhaseIdxW'(1);
			if (next_phase.last_phase)
				busy_q <= 1'b0;
		end
	end

	// Request payload needs no reset; it is qualified by busy_q.
	always_ff @(posedge clk) begin
		if (take) begin
			req_q.action    <= req.action;
			req_q.data_byte <= req.data_byte;
			req_q.row       <= req.row;
			req_q.column    <= req.column;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (phase.ready)
			out_valid_q <= 1'b0;
	end

	// Hold the phase while stalled, load the next one on advance.
	always_ff @(posedge clk) begin
		if (advance)
			out_q <= next_phase;
	end

	assign phase.valid       = out_valid_q;
	assign phase.reg_select  = out_q.reg_select;
	assign phase.enable_line = out_q.enable_line;
	assign phase.bus_data    = out_q.bus_data;
	assign phase.hold_ticks  = out_q.hold_ticks;
	assign phase.last_phase  = out_q.last_phase;

endmodule

// ----- hw/rtl/clws_checker.sv -----
`timescale 1ns / 1ps

module clws_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [1:0]                     cfg_index,
	input logic [clws_pkg::CfgDataW-1:0]  cfg_data,
	input logic                           phase_valid,
	input logic                           phase_ready,
	input logic                           phase_enable_line,
	input logic [7:0]                     phase_bus_data,
	input logic [clws_pkg::HoldW-1:0]     phase_hold_ticks,
	input logic                           phase_last_phase
);
	import clws_pkg::*;

	logic mode_q;

	// Mirror the bus mode from the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_we && cfg_index == CFG_BUS_MODE)
			mode_q <= cfg_data[0];
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid && !phase_ready |=> phase_valid && $stable(phase_bus_data)
			&& $stable(phase_hold_ticks) && $stable(phase_last_phase))
		else $error("phase changed while stalled");

	a_last_en_low: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid && phase_last_phase |-> !phase_enable_line)
		else $error("final phase left EN high");

	a_nibble_low: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid && mode_q |-> phase_bus_data[3:0] == 4'h0)
		else $error("D3..D0 driven in nibble mode");

	a_hold_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_valid |-> phase_hold_ticks != '0)
		else $error("zero hold time");

endmodule

bind char_lcd_write_sequencer_top clws_checker u_clws_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.cfg_we            (cfg_we),
	.cfg_index         (cfg_index),
	.cfg_data          (cfg_data),
	.phase_valid       (phase.valid),
	.phase_ready       (phase.ready),
	.phase_enable_line (phase.enable_line),
	.phase_bus_data    (phase.bus_data),
	.phase_hold_ticks  (phase.hold_ticks),
	.phase_last_phase  (phase.last_phase)
);

// ----- tb/tb_char_lcd_write_sequencer_top.sv -----
`timescale 1ns / 1ps

module tb_char_lcd_write_sequencer_top;
	import clws_pkg::*;

	// Index past the end of the register list; the block must ignore writes here.
	localparam logic [1:0] CfgIndexUnused = 2'd3;
	// Run limit in nanoseconds for the whole run.
	localparam longint RunLimitNs = 64'd10_000_000;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	clws_req_if   req_ch();
	clws_phase_if phase_ch();

	char_lcd_write_sequencer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.phase     (phase_ch)
	);

	// Mirror of the configuration registers, updated on each write.
	logic               nibble_bus;
	logic [StrobeW-1:0] strobe_hold;
	logic [HoldW-1:0]   powerup_hold;

	// Pin phases still owed by the block, oldest first.
	phase_t expected_phases[$];

	int mismatches       = 0;
	int requests_sent    = 0;
	int phases_checked   = 0;
	int cursors_rejected = 0;

	// Idle control: largest random gap per transaction on each side, and a
	// one-shot long hold-off for the receiver.
	int src_idle_max      = 8;
	int sink_idle_max     = 8;
	int sink_hold_cycles  = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Global watchdog: a hung handshake ends the run here.
	initial begin
		#(RunLimitNs);
		$display("%0t: timeout, %0d pin phases still expected", $time, expected_phases.size());
		$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Phase predictor
	// ------------------------------------------------------------------

	// Queue one pin phase; a zero hold register still holds for one tick.
	function automatic void push_phase(logic rs, logic en, logic [7:0] bus,
		logic [HoldW-1:0] hold);
		phase_t p;
		p.reg_select  = rs;
		p.enable_line = en;
		p.bus_data    = bus;
		p.hold_ticks  = (hold == '0) ? HoldW'(1) : hold;
		p.last_phase  = 1'b0;
		expected_phases.push_back(p);
	endfunction

	// EN high then EN low with the same bus levels.
	function automatic void push_strobe(logic rs, logic [7:0] bus);
		push_phase(rs, 1'b1, bus, HoldW'(strobe_hold));
		push_phase(rs, 1'b0, bus, HoldW'(strobe_hold));
	endfunction

	// One byte: a single strobe on the wide bus, high then low nibble on D7..D4
	// on the narrow one.
	function automatic void push_byte(logic rs, logic [7:0] b);
		if (!nibble_bus) begin
			push_strobe(rs, b);
		end else begin
			push_strobe(rs, b & NibbleMask);
			push_strobe(rs, {b[3:0], 4'b0000} & NibbleMask);
		end
	endfunction

	// Expand one request into its pin phases and flag the final one.
	function automatic void predict_phases(action_t act, logic [7:0] data_byte,
		logic [1:0] row, logic [4:0] column);
		int         queued;
		logic [7:0] base;
		phase_t     tail;
		queued = expected_phases.size();
		case (act)
			ACT_CMD: begin
				push_byte(1'b0, data_byte);
			end
			ACT_CHAR: begin
				push_byte(1'b1, data_byte);
			end
			ACT_INIT: begin
				push_phase(1'b0, 1'b0, 8'h00, powerup_hold);
				if (!nibble_bus) begin
					push_byte(1'b0, CmdFunc8);
				end else begin
					push_byte(1'b0, CmdHome4);
					push_byte(1'b0, CmdFunc4);
				end
				push_byte(1'b0, CmdDispOn);
				push_byte(1'b0, CmdClear);
				push_byte(1'b0, CmdEntry);
			end
			ACT_CURSOR: begin
				// Rows above 1 or columns above 15 produce nothing at all.
				if (row <= 2'd1 && column <= 5'd15) begin
					base = (row == 2'd0) ? CmdRow0Base : CmdRow1Base;
					push_byte(1'b0, base);
					push_byte(1'b0, base + {3'b000, column});
				end else begin
					cursors_rejected++;
				end
			end
			default: begin
			end
		endcase
		if (expected_phases.size() > queued) begin
			tail = expected_phases.pop_back();
			tail.last_phase = 1'b1;
			expected_phases.push_back(tail);
		end
	endfunction

	// ------------------------------------------------------------------
	// Phase receiver and checker
	// ------------------------------------------------------------------

	// Receiver: draw a gap before each transaction, or take the long hold-off
	// when a test asks for one; count the stall here, not in the test.
	initial begin : phase_receiver
		int gap;
		phase_ch.ready <= 1'b0;
		forever begin
			if (sink_hold_cycles > 0) begin
				gap = sink_hold_cycles;
				sink_hold_cycles = 0;
			end else begin
				gap = (sink_idle_max > 0) ? $urandom_range(0, sink_idle_max) : 0;
			end
			if (gap > 0) begin
				phase_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			phase_ch.ready <= 1'b1;
			do @(posedge clk); while (!phase_ch.valid);
		end
	end

	function automatic void check_field(string name, logic [HoldW-1:0] want,
		logic [HoldW-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Compare every accepted phase against the oldest expectation.
	always @(posedge clk) begin : phase_checker
		phase_t want;
		if (arst_n && phase_ch.valid && phase_ch.ready) begin
			if (expected_phases.size() == 0) begin
				$display("%0t: unexpected pin phase, expected none, got rs=%0b en=%0b bus=0x%02h",
					$time, phase_ch.reg_select, phase_ch.enable_line, phase_ch.bus_data);
				mismatches++;
			end else begin
				want = expected_phases.pop_front();
				check_field("reg_select", HoldW'(want.reg_select), HoldW'(phase_ch.reg_select));
				check_field("enable_line", HoldW'(want.enable_line),
					HoldW'(phase_ch.enable_line));
				check_field("bus_data", HoldW'(want.bus_data), HoldW'(phase_ch.bus_data));
				check_field("hold_ticks", want.hold_ticks, phase_ch.hold_ticks);
				check_field("last_phase", HoldW'(want.last_phase), HoldW'(phase_ch.last_phase));
				phases_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Request driver and configuration
	// ------------------------------------------------------------------

	// Offer one request after a random gap and hold it until the transaction.
	// Valid stays high on return, so a request sent with no gap follows without valid dropping.
	task automatic send_request(action_t act, logic [7:0] data_byte, logic [1:0] row,
		logic [4:0] column);
		int gap;
		gap = (src_idle_max > 0) ? $urandom_range(0, src_idle_max) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid     <= 1'b1;
		req_ch.action    <= act;
		req_ch.data_byte <= data_byte;
		req_ch.row       <= row;
		req_ch.column    <= column;
		do @(posedge clk); while (!req_ch.ready);
		predict_phases(act, data_byte, row, column);
		requests_sent++;
	endtask

	// Drop valid, wait for every owed phase, then give a silent rejected cursor
	// request time to leave the block before anything touches the registers.
	task automatic drain_phases();
		req_ch.valid <= 1'b0;
		while (expected_phases.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [CfgDataW-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			CFG_BUS_MODE:     nibble_bus   = value[0];
			CFG_STROBE_HOLD:  strobe_hold  = value[StrobeW-1:0];
			CFG_POWERUP_HOLD: powerup_hold = value[HoldW-1:0];
			default: begin
			end
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timing(logic bus4, logic [StrobeW-1:0] strobe,
		logic [HoldW-1:0] powerup);
		write_register(CFG_BUS_MODE, CfgDataW'(bus4));
		write_register(CFG_STROBE_HOLD, CfgDataW'(strobe));
		write_register(CFG_POWERUP_HOLD, CfgDataW'(powerup));
	endtask

	// Mostly well-formed requests; cursor requests land in range most of the
	// time, and unused fields carry noise.
	task automatic send_random_request();
		action_t    act;
		logic [1:0] row;
		logic [4:0] column;
		act    = action_t'($urandom_range(0, 3));
		row    = 2'($urandom_range(0, 3));
		column = 5'($urandom_range(0, 31));
		if (act == ACT_CURSOR && $urandom_range(0, 9) < 8) begin
			row    = 2'($urandom_range(0, 1));
			column = 5'($urandom_range(0, 15));
		end
		send_request(act, 8'($urandom_range(0, 255)), row, column);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset values: eight-bit bus, 4000-tick strobe, 5000000-tick power-up.
	task automatic test_reset_defaults();
		send_request(ACT_INIT, 8'h00, 2'd0, 5'd0);
		send_request(ACT_CMD, 8'h01, 2'd3, 5'd31);
		send_request(ACT_CHAR, 8'h41, 2'd0, 5'd0);
		drain_phases();
	endtask

	// Eight-bit bus with the shortest holds: byte extremes, both rows, both
	// column ends and every flavor of an out-of-range cursor.
	task automatic test_eight_bit_bus();
		set_timing(1'b0, 16'd1, 24'd1);
		send_request(ACT_CMD, 8'h00, 2'd0, 5'd0);
		send_request(ACT_CMD, 8'hFF, 2'd0, 5'd0);
		send_request(ACT_CHAR, 8'hA5, 2'd1, 5'd7);
		send_request(ACT_CURSOR, 8'hFF, 2'd0, 5'd0);
		send_request(ACT_CURSOR, 8'h00, 2'd1, 5'd15);
		send_request(ACT_CURSOR, 8'h00, 2'd2, 5'd0);
		send_request(ACT_CURSOR, 8'h00, 2'd0, 5'd16);
		send_request(ACT_CURSOR, 8'h00, 2'd3, 5'd31);
		send_request(ACT_INIT, 8'hFF, 2'd3, 5'd31);
		drain_phases();
	endtask

	// Nibble bus with the longest holds.
	task automatic test_nibble_bus();
		set_timing(1'b1, 16'hFFFF, 24'hFFFFFF);
		send_request(ACT_CMD, 8'hFF, 2'd0, 5'd0);
		send_request(ACT_CHAR, 8'h0F, 2'd0, 5'd0);
		send_request(ACT_INIT, 8'h5A, 2'd1, 5'd1);
		send_request(ACT_CURSOR, 8'h00, 2'd1, 5'd0);
		send_request(ACT_CURSOR, 8'h00, 2'd0, 5'd15);
		send_request(ACT_CURSOR, 8'h00, 2'd1, 5'd16);
		drain_phases();
	endtask

	// Zero holds, the unused index, and data bits above each register's width.
	task automatic test_register_corners();
		write_register(CFG_BUS_MODE, 24'hFFFFFF);
		write_register(CFG_STROBE_HOLD, 24'hAB0000);
		write_register(CFG_POWERUP_HOLD, 24'h000000);
		write_register(CfgIndexUnused, 24'h123456);
		send_request(ACT_INIT, 8'h00, 2'd0, 5'd0);
		send_request(ACT_CHAR, 8'hC3, 2'd0, 5'd0);
		drain_phases();
		write_register(CFG_BUS_MODE, 24'hFFFFFE);
		write_register(CFG_STROBE_HOLD, 24'hFF1234);
		send_request(ACT_CMD, 8'h3C, 2'd2, 5'd20);
		drain_phases();
	endtask

	// Stall the receiver for a long stretch while requests keep coming, so the
	// block fills and pushes back; then pause until everything has drained.
	task automatic test_sink_stall();
		set_timing(1'b1, 16'd250, 24'd77);
		src_idle_max     = 0;
		sink_idle_max    = 0;
		sink_hold_cycles = 300;
		repeat (25) send_random_request();
		req_ch.valid <= 1'b0;
		while (expected_phases.size() != 0) @(posedge clk);
		src_idle_max  = 8;
		sink_idle_max = 8;
		repeat (5) send_random_request();
		drain_phases();
	endtask

	// Random requests under one register setting, with each side's idle setting
	// redrawn every 20 transactions as idle or idle-free.
	task automatic run_random_block(int count, logic bus4, logic [StrobeW-1:0] strobe,
		logic [HoldW-1:0] powerup);
		set_timing(bus4, strobe, powerup);
		for (int i = 0; i < count; i++) begin
			if (i % 20 == 0) begin
				src_idle_max  = ($urandom_range(0, 2) == 0) ? 0 : 8;
				sink_idle_max = ($urandom_range(0, 2) == 0) ? 0 : 8;
			end
			send_random_request();
		end
		drain_phases();
	endtask

	task automatic test_random_traffic();
		run_random_block(80, 1'b0, 16'd1, 24'd1);
		run_random_block(80, 1'b1, 16'hFFFF, 24'hFFFFFF);
		run_random_block(80, 1'b0, 16'($urandom_range(1, 65535)),
			24'($urandom_range(1, 16777215)));
		run_random_block(80, 1'b1, 16'($urandom_range(1, 65535)),
			24'($urandom_range(1, 16777215)));
		run_random_block(80, 1'($urandom_range(0, 1)), 16'h0000, 24'h000000);
		src_idle_max  = 8;
		sink_idle_max = 8;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		// Hold every input at a known value through reset.
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_BUS_MODE;
		cfg_data         <= '0;
		req_ch.valid     <= 1'b0;
		req_ch.action    <= ACT_CMD;
		req_ch.data_byte <= 8'h00;
		req_ch.row       <= 2'd0;
		req_ch.column    <= 5'd0;
		nibble_bus       = 1'b0;
		strobe_hold      = StrobeHoldReset;
		powerup_hold     = PowerupHoldReset;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_eight_bit_bus();
		test_nibble_bus();
		test_register_corners();
		test_sink_stall();
		test_random_traffic();

		// Drop the request line, wait out every owed phase, then allow a
		// few quiet cycles in case the block emits something stray.
		drain_phases();
		repeat (30) @(posedge clk);

		$display("%0d requests sent, %0d cursor requests out of range, %0d pin phases checked",
			requests_sent, cursors_rejected, phases_checked);
		$display("covered: both bus widths, hold extremes and zero holds, unused index, long stall");
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/clws_pkg.sv
hw/rtl/clws_if.sv
hw/rtl/clws_phase_gen.sv
hw/rtl/char_lcd_write_sequencer_top.sv
hw/rtl/clws_checker.sv
tb/tb_char_lcd_write_sequencer_top.sv
